### hdl/pfu_pkg.sv
`timescale 1ns / 1ps

package pfu_pkg;

  localparam int WordW  = 32;
  localparam int ByteW  = 8;
  localparam int CntW   = 6;
  localparam int HeldW  = 8;
  localparam int KindW  = 2;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;
  localparam int OutDataW = 64;

  localparam logic [HeldW-1:0] FifoHalf = 8'd128;
  localparam logic [HeldW-1:0] CountMax = 8'd255;

  localparam logic [0:0] RegIrqOnEmpty = 1'b0;
  localparam logic [0:0] RegIrqOnHalf  = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_CMD   = 2'd0,
    KIND_PARAM = 2'd1,
    KIND_ZERO  = 2'd2
  } pfu_kind_t;

  typedef enum logic [1:0] {
    MODE_CMD,
    MODE_PARAM,
    MODE_ZERO
  } pfu_mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } pfu_state_t;

  typedef struct packed {
    pfu_kind_t               kind;
    logic [ByteW-1:0]        cmd;
    logic [CntW-1:0]         cnt;
    logic [WordW-1:0]        pword;
    logic                    rel;
    logic [HeldW-1:0]        held_out;
    logic                    last;
    logic [HeldW-1:0]        owed_next;
    logic [HeldW-1:0]        held_next;
  } pfu_step_t;

  function automatic logic [CntW-1:0] param_count(input logic [ByteW-1:0] c);
    logic [CntW-1:0] n;
    n = '0;
    case (c) inside
      8'h10, 8'h12, 8'h13, 8'h14: n = 6'd1;
      8'h16, 8'h18:               n = 6'd16;
      8'h17, 8'h19:               n = 6'd12;
      8'h1a:                      n = 6'd9;
      8'h1b, 8'h1c:               n = 6'd3;
      8'h23:                      n = 6'd2;
      [8'h20:8'h2b]:              n = 6'd1;
      [8'h30:8'h33]:              n = 6'd1;
      8'h34:                      n = 6'd32;
      8'h40, 8'h50, 8'h60:        n = 6'd1;
      8'h70:                      n = 6'd3;
      8'h71:                      n = 6'd2;
      8'h72:                      n = 6'd1;
      default:                    n = '0;
    endcase
    return n;
  endfunction

endpackage

### hdl/packed_command_fifo_unpacker_unit.sv
`timescale 1ns / 1ps
// Packed command port unpacker.
// Input stream (s_*): one 32-bit word per beat, written to the command port.
// Output stream (m_*): one beat per FIFO entry the word produces, 1 to 4
// beats per word; m_tlast marks the final beat of a word and m_tuser carries
// the entry kind (command byte, parameter word, zero word).
// Configuration: APB port, irq_on_empty at 0x0 and irq_on_half at 0x4.
// The input word is registered on acceptance, and its results then pass
// through the output register. A word occupies the block until its last
// result is loaded, the byte step unit handling one byte or one parameter
// per cycle while the output register is free; s_tready stays low from
// acceptance until the last result has been loaded into the output register.
// The output register holds a result while m_tready is low; the sequencer
// waits and no result is lost or repeated.
// Reset clears the owed-parameter and held-entry counters, both interrupt
// enables, and the output valid flag, and leaves the block ready.
module packed_command_fifo_unpacker_unit import pfu_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [WordW-1:0]    s_tdata,  // [31:0] word
  output logic                m_tvalid,
  input  logic                m_tready,
  // [7:0] command_byte, [13:8] param_count, [45:14] param_word,
  // [46] release_res, [54:47] held_count, [55] fifo_empty,
  // [56] fifo_below_half, [57] irq, [63:58] zero
  output logic [OutDataW-1:0] m_tdata,
  output logic [KindW-1:0]    m_tuser,  // [1:0] entry_kind
  output logic                m_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  pfu_state_t       state, state_next;
  pfu_mode_t        mode;
  logic [WordW-1:0] word;
  logic [HeldW-1:0] owed;
  logic [HeldW-1:0] held;
  logic             irq_on_empty;
  logic             irq_on_half;
  pfu_step_t        step;
  logic             in_fire;
  logic             load;
  logic             empty;
  logic             below_half;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign load     = (state == ST_RUN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_on_empty <= 1'b0;
      irq_on_half  <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        RegIrqOnEmpty: irq_on_empty <= pwdata[0];
        RegIrqOnHalf:  irq_on_half  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegIrqOnEmpty: prdata[0] = irq_on_empty;
      RegIrqOnHalf:  prdata[0] = irq_on_half;
      default:       prdata = '0;
    endcase
  end

  pfu_step u_step (
    .mode (mode),
    .word (word),
    .owed (owed),
    .held (held),
    .step (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_RUN;
      ST_RUN:  if (load && step.last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word <= s_tdata;
      if (owed != '0) begin
        mode <= MODE_PARAM;
      end else if (s_tdata == '0) begin
        mode <= MODE_ZERO;
      end else begin
        mode <= MODE_CMD;
      end
    end else if (load) begin
      word <= word >> ByteW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
      held <= '0;
    end else if (load) begin
      owed <= step.owed_next;
      held <= step.held_next;
    end
  end

  assign empty      = (step.held_out == '0);
  assign below_half = (step.held_out < FifoHalf);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= step.kind;
      m_tlast <= step.last;
      m_tdata <= {6'd0,
                  (irq_on_half && below_half) || (irq_on_empty && empty),
                  below_half, empty, step.held_out, step.rel,
                  step.pword, step.cnt, step.cmd};
    end
  end

  a_release_empties: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[46] |-> m_tlast && (m_tdata[54:47] == '0))
    else $error("release beat with nonzero held count or not last");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[55] == (m_tdata[54:47] == '0)))
    else $error("empty flag disagrees with held count");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_RUN) && !s_tready)
    else $error("sequencer did not start after input beat");

  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    load && step.last |=> (state == ST_IDLE))
    else $error("sequencer still busy after final result");

  a_zero_owes: assert property (@(posedge clk) disable iff (rst)
    load && (step.kind == KIND_ZERO) |=> (owed == '0) && (held == '0))
    else $error("zero word left counters nonzero");

endmodule

### hdl/pfu_step.sv
`timescale 1ns / 1ps

module pfu_step import pfu_pkg::*; (
  input  pfu_mode_t          mode,
  input  logic [WordW-1:0]   word,
  input  logic [HeldW-1:0]   owed,
  input  logic [HeldW-1:0]   held,
  output pfu_step_t          step
);

  logic [ByteW-1:0] c;
  logic [CntW-1:0]  np;
  logic [HeldW:0]   owed_sum;
  logic [HeldW-1:0] owed_sat;
  logic [HeldW-1:0] held_inc;
  logic [HeldW-1:0] held_cmd;
  logic [HeldW-1:0] owed_dec;
  logic             fin;

  assign c        = word[ByteW-1:0];
  assign np       = param_count(c);
  assign owed_sum = {1'b0, owed} + {{(HeldW+1-CntW){1'b0}}, np};
  assign owed_sat = owed_sum[HeldW] ? CountMax : owed_sum[HeldW-1:0];
  assign held_inc = (held == CountMax) ? CountMax : held + 8'd1;
  assign held_cmd = (np == '0) ? held_inc : held;
  assign owed_dec = owed - 8'd1;
  assign fin      = (word[WordW-1:ByteW] == '0);

  always_comb begin
    step = '0;
    case (mode)
      MODE_PARAM: begin
        step.kind      = KIND_PARAM;
        step.pword     = word;
        step.rel       = (owed_dec == '0);
        step.held_out  = step.rel ? '0 : held_inc;
        step.last      = 1'b1;
        step.owed_next = owed_dec;
        step.held_next = step.held_out;
      end
      MODE_ZERO: begin
        step.kind      = KIND_ZERO;
        step.rel       = 1'b1;
        step.held_out  = '0;
        step.last      = 1'b1;
        step.owed_next = owed;
        step.held_next = '0;
      end
      MODE_CMD: begin
        step.kind      = KIND_CMD;
        step.cmd       = c;
        step.cnt       = np;
        step.last      = fin;
        step.rel       = fin && (owed_sat == '0);
        step.held_out  = step.rel ? '0 : held_cmd;
        step.owed_next = owed_sat;
        step.held_next = step.held_out;
      end
      default: step = '0;
    endcase
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pfu_pkg::*;

  localparam int StallLimit = 2000;
  localparam int PhaseWords = 38;
  localparam logic [AddrW-1:0] AddrIrqOnEmpty = {RegIrqOnEmpty, 2'b00};
  localparam logic [AddrW-1:0] AddrIrqOnHalf  = {RegIrqOnHalf, 2'b00};

  typedef struct packed {
    pfu_kind_t   kind;
    logic [7:0]  code;
    logic [5:0]  cnt;
    logic [31:0] pword;
    logic        rel;
    logic [7:0]  held;
    logic        empty;
    logic        below_half;
    logic        irq;
    logic        last;
  } fifo_entry_t;

  typedef struct packed {
    logic [31:0] word;
    logic        has_want;
    fifo_entry_t want;
  } dir_row_t;

  localparam fifo_entry_t NoEntry = '0;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [WordW-1:0]    s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic [KindW-1:0]    m_tuser;
  logic                m_tlast;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  packed_command_fifo_unpacker_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state
  int          owed_params;
  int          held_entries;
  logic        irq_en_empty;
  logic        irq_en_half;
  fifo_entry_t word_entries[$];
  fifo_entry_t pending_entries[$];

  int   errors;
  int   words_sent;
  int   entries_seen;
  int   idle_cycles;
  logic no_gaps;

  dir_row_t dir_rows [0:17] = '{
    '{32'h0000_0000, 1'b1,
      '{KIND_ZERO, 8'h00, 6'd0, 32'h0, 1'b1, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{32'h0000_00ff, 1'b1,
      '{KIND_CMD, 8'hff, 6'd0, 32'h0, 1'b1, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{32'h0000_0080, 1'b1,
      '{KIND_CMD, 8'h80, 6'd0, 32'h0, 1'b1, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{32'h0000_007f, 1'b1,
      '{KIND_CMD, 8'h7f, 6'd0, 32'h0, 1'b1, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{32'h0000_0070, 1'b1,
      '{KIND_CMD, 8'h70, 6'd3, 32'h0, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{32'hffff_ffff, 1'b1,
      '{KIND_PARAM, 8'h00, 6'd0, 32'hffff_ffff, 1'b0, 8'd1, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{32'h0000_0000, 1'b1,
      '{KIND_PARAM, 8'h00, 6'd0, 32'h0, 1'b0, 8'd2, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{32'h1234_5678, 1'b1,
      '{KIND_PARAM, 8'h00, 6'd0, 32'h1234_5678, 1'b1, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{32'h0100_0000, 1'b0, NoEntry},
    '{32'h8080_8080, 1'b0, NoEntry},
    '{32'h0000_2310, 1'b0, NoEntry},
    '{32'haaaa_aaaa, 1'b0, NoEntry},
    '{32'h5555_5555, 1'b0, NoEntry},
    '{32'h0000_0000, 1'b1,
      '{KIND_PARAM, 8'h00, 6'd0, 32'h0, 1'b1, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{32'h0072_8015, 1'b0, NoEntry},
    '{32'h7fff_ffff, 1'b0, NoEntry},
    '{32'h0000_0001, 1'b1,
      '{KIND_CMD, 8'h01, 6'd0, 32'h0, 1'b1, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{32'h0034_0000, 1'b0, NoEntry}
  };

  function automatic int params_for(logic [7:0] code);
    case (code)
      8'h10, 8'h12, 8'h13, 8'h14,
      8'h20, 8'h21, 8'h22, 8'h24, 8'h25, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2a, 8'h2b,
      8'h30, 8'h31, 8'h32, 8'h33,
      8'h40, 8'h50, 8'h60, 8'h72: return 1;
      8'h23, 8'h71:               return 2;
      8'h1b, 8'h1c, 8'h70:        return 3;
      8'h1a:                      return 9;
      8'h17, 8'h19:               return 12;
      8'h16, 8'h18:               return 16;
      8'h34:                      return 32;
      default:                    return 0;
    endcase
  endfunction

  function automatic int capped(int v);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic fifo_entry_t make_entry(pfu_kind_t kind, logic [7:0] code,
                                             logic [5:0] cnt, logic [31:0] pword,
                                             logic rel, logic [7:0] held,
                                             logic last);
    fifo_entry_t e;
    e.kind       = kind;
    e.code       = code;
    e.cnt        = cnt;
    e.pword      = pword;
    e.rel        = rel;
    e.held       = held;
    e.empty      = (held == 8'd0);
    e.below_half = (held < FifoHalf);
    e.irq        = (irq_en_empty & e.empty) | (irq_en_half & e.below_half);
    e.last       = last;
    return e;
  endfunction

  // Split one port word into FIFO entries and advance the counters.
  task automatic unpack_word(input logic [31:0] w);
    logic [31:0] rest;
    logic [7:0]  code;
    int          np;
    logic        rel;
    fifo_entry_t tail;
    word_entries.delete();
    if (owed_params != 0) begin
      owed_params--;
      held_entries = capped(held_entries + 1);
      rel = (owed_params == 0);
      if (rel) held_entries = 0;
      word_entries.push_back(make_entry(KIND_PARAM, 8'h00, 6'd0, w, rel,
                                        held_entries[7:0], 1'b1));
    end else if (w == 32'h0) begin
      held_entries = 0;
      word_entries.push_back(make_entry(KIND_ZERO, 8'h00, 6'd0, 32'h0, 1'b1,
                                        8'd0, 1'b1));
    end else begin
      rest = w;
      while (rest != 32'h0) begin
        code = rest[7:0];
        np = params_for(code);
        owed_params = capped(owed_params + np);
        if (np == 0) held_entries = capped(held_entries + 1);
        word_entries.push_back(make_entry(KIND_CMD, code, np[5:0], 32'h0, 1'b0,
                                          held_entries[7:0], 1'b0));
        rest = rest >> 8;
      end
      rel = (owed_params == 0);
      if (rel) held_entries = 0;
      tail = word_entries[word_entries.size()-1];
      word_entries[word_entries.size()-1] =
        make_entry(KIND_CMD, tail.code, tail.cnt, 32'h0, rel,
                   rel ? 8'd0 : tail.held, 1'b1);
    end
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'h10 + 8'($urandom_range(0, 15));
      2:       return 8'h20 + 8'($urandom_range(0, 15));
      3:       return 8'h30 + 8'($urandom_range(0, 7));
      default: return {4'($urandom_range(4, 7)), 4'h0} + 8'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [31:0] pick_cmd_word();
    logic [31:0] w;
    int          n;
    w = '0;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) w[8*i +: 8] = pick_code();
    return w;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(input logic [31:0] w, input logic has_want,
                           input fifo_entry_t want);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    unpack_word(w);
    if (has_want) begin
      pending_entries.push_back(want);
    end else begin
      foreach (word_entries[k]) pending_entries.push_back(word_entries[k]);
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [AddrW-1:0] addr, input logic value);
    logic [DataW-1:0] rd;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {{(DataW-1){1'b0}}, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == AddrIrqOnEmpty) irq_en_empty = value;
    else irq_en_half = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd !== {{(DataW-1){1'b0}}, value}) begin
      $display("%0t: register 0x%0h read back expected %0h got %0h",
               $time, addr, value, rd);
      errors++;
    end
  endtask

  // Hold until every expected beat has arrived, then let the block settle.
  task automatic settle_idle();
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  initial begin
    fifo_entry_t want;
    int          stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected beat, expected none got tdata %h tuser %h",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_entries.pop_front();
        check_field("entry_kind", 32'(want.kind), 32'(m_tuser));
        check_field("command_byte", 32'(want.code), 32'(m_tdata[7:0]));
        check_field("param_count", 32'(want.cnt), 32'(m_tdata[13:8]));
        check_field("param_word", want.pword, m_tdata[45:14]);
        check_field("release_res", 32'(want.rel), 32'(m_tdata[46]));
        check_field("held_count", 32'(want.held), 32'(m_tdata[54:47]));
        check_field("fifo_empty", 32'(want.empty), 32'(m_tdata[55]));
        check_field("fifo_below_half", 32'(want.below_half), 32'(m_tdata[56]));
        check_field("irq", 32'(want.irq), 32'(m_tdata[57]));
        check_field("pad", 32'h0, 32'(m_tdata[63:58]));
        check_field("last", 32'(want.last), 32'(m_tlast));
      end
      entries_seen++;
      @(negedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("packed_command_fifo_unpacker_unit: mismatch");
    $finish;
  end

  initial begin
    int          target;
    logic        en_empty;
    logic        en_half;
    logic [31:0] w;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    no_gaps      = 1'b0;
    owed_params  = 0;
    held_entries = 0;
    irq_en_empty = 1'b0;
    irq_en_half  = 1'b0;
    errors       = 0;
    words_sent   = 0;
    entries_seen = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].has_want,
                                    dir_rows[i].want);
    s_tvalid = 1'b0;
    settle_idle();

    for (int phase = 0; phase < 4; phase++) begin
      en_empty = (phase == 0) || (phase == 2);
      en_half  = (phase == 1) || (phase == 2);
      write_reg(AddrIrqOnEmpty, en_empty);
      write_reg(AddrIrqOnHalf, en_half);
      no_gaps = (phase == 2);
      target = words_sent + PhaseWords;
      while (words_sent < target) begin
        if (owed_params != 0) begin
          w = $urandom;
        end else begin
          case ($urandom_range(0, 9))
            0:       w = 32'h0;
            1:       w = $urandom;
            default: w = pick_cmd_word();
          endcase
        end
        send_word(w, 1'b0, NoEntry);
      end
      s_tvalid = 1'b0;
      no_gaps  = 1'b0;
      settle_idle();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d command port words, checked %0d FIFO entry beats,", words_sent,
             entries_seen);
    $display("across all four interrupt enable settings with random stalls.");
    if (errors == 0) begin
      $display("packed_command_fifo_unpacker_unit: match");
    end else begin
      $display("packed_command_fifo_unpacker_unit: mismatch");
    end
    $finish;
  end

endmodule

### packed_command_fifo_unpacker_unit.f
hdl/pfu_pkg.sv
hdl/pfu_step.sv
hdl/packed_command_fifo_unpacker_unit.sv
dv/tb_top.sv
